[rtl/sfa_pkg.sv]
// Shared types and constants of the social force avoidance pipeline.
// It has no dependencies. The top level uses it through scoped names.
package sfa_pkg;

    // Register indexes of the configuration port.
    localparam logic CFG_RADIUS   = 1'b0;
    localparam logic CFG_STRENGTH = 1'b1;

    localparam logic [23:0] RADIUS_RESET   = 24'd512;
    localparam logic [15:0] STRENGTH_RESET = 16'd256;

    // log2(e) in Q.16.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // Upper limit on the integer part of the exponent before the potential underflows.
    localparam logic [6:0] EXP_SHIFT_LIMIT = 7'd17;

    // 2^(-k/16) in Q.16, for k = 0 to 16.
    localparam logic [16:0] EXP2_TAB [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    // Per-request flags that ride along the back end of the pipeline.
    typedef struct packed {
        logic valid;
        logic inr;
        logic nz;
        logic negx;
        logic negy;
    } t_flags;

endpackage

[rtl/sfa_delay.sv]
// Fixed-depth register delay line used to align side data with the long arithmetic units.
// It has no dependencies.
module sfa_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_pipe[i] <= '0;
            end
        end else begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

[rtl/sfa_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// It has no dependencies.
module sfa_isqrt #(
    parameter int IN_W = 60
) (
    input  logic              i_clk,
    input  logic [IN_W-1:0]   i_x,
    output logic [IN_W/2-1:0] o_root
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 2;

    logic [IN_W-1:0]  r_x    [1:OUT_W];
    logic [RW-1:0]    r_rem  [1:OUT_W];
    logic [OUT_W-1:0] r_root [1:OUT_W];

    for (genvar g = 1; g <= OUT_W; g++) begin : g_stage
        logic [IN_W-1:0]  w_x;
        logic [RW-1:0]    w_rem;
        logic [OUT_W-1:0] w_root;
        logic [RW-1:0]    w_cur;
        logic [RW-1:0]    w_trial;

        if (g == 1) begin : g_first
            assign w_x    = i_x;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_x    = r_x[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        // Bring down the next two bits and try the next root bit.
        assign w_cur   = {w_rem[RW-3:0], w_x[IN_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            r_x[g] <= w_x << 2;
            if (w_cur >= w_trial) begin
                r_rem[g]  <= w_cur - w_trial;
                r_root[g] <= {w_root[OUT_W-2:0], 1'b1};
            end else begin
                r_rem[g]  <= w_cur;
                r_root[g] <= {w_root[OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[OUT_W];

endmodule

[rtl/sfa_div.sv]
// Pipelined restoring divider with a saturating quotient of Q_W bits.
// It has no dependencies.
module sfa_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 24,
    parameter int Q_W   = 22
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int HI_W = NUM_W - Q_W;
    localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_lo  [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic             r_sat [0:Q_W];

    // The quotient fits in Q_W bits only when the upper numerator part is below the divisor.
    always_ff @(posedge i_clk) begin
        r_sat[0] <= CW'(i_num[NUM_W-1:Q_W]) >= CW'(i_den);
        r_rem[0] <= DEN_W'(i_num[NUM_W-1:Q_W]);
        r_lo[0]  <= i_num[Q_W-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
    end

    for (genvar g = 1; g <= Q_W; g++) begin : g_stage
        logic [DEN_W:0] w_cur;
        logic [DEN_W:0] w_dd;

        assign w_cur = {r_rem[g-1], r_lo[g-1][Q_W-1]};
        assign w_dd  = {1'b0, r_den[g-1]};

        always_ff @(posedge i_clk) begin
            r_lo[g]  <= r_lo[g-1] << 1;
            r_den[g] <= r_den[g-1];
            r_sat[g] <= r_sat[g-1];
            if (w_cur >= w_dd) begin
                r_rem[g] <= DEN_W'(w_cur - w_dd);
                r_q[g]   <= {r_q[g-1][Q_W-2:0], 1'b1};
            end else begin
                r_rem[g] <= DEN_W'(w_cur);
                r_q[g]   <= {r_q[g-1][Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_sat[Q_W] ? '1 : r_q[Q_W];

endmodule

[rtl/social_force_avoidance.sv]
// Social force avoidance top level: elliptical repulsion between two agents.
// It depends on sfa_pkg, sfa_delay, sfa_isqrt and sfa_div.
//
// The block takes one agent-pair request in every clock cycle once reset has been released
// (o_busy is high only during reset and in the cycle after it), and returns exactly one
// result per request, in request order. The result is on the output ports for one cycle
// while o_done is high; there is no way to hold it off, so the receiver must take it then.
// The result is formed by a chain of long arithmetic units: two square roots of 30 stages
// run in parallel on |d| and on |d - v*dt|, a square root of 31 stages gives the ellipse
// axis, a divider of 23 stages forms b/R, and a divider of 17 stages normalizes the force,
// with single-stage multiplies and the exponential table in between and a final sign stage
// at the end. Configuration writes take effect at once and must only be made while no
// request is in flight.
module social_force_avoidance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [23:0] i_self_pos_x,
    input  logic signed [23:0] i_self_pos_y,
    input  logic signed [23:0] i_other_pos_x,
    input  logic signed [23:0] i_other_pos_y,
    input  logic signed [15:0] i_other_vel_x,
    input  logic signed [15:0] i_other_vel_y,
    input  logic        [15:0] i_time_step,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic        [23:0] i_cfg_data,
    output logic               o_done,
    output logic signed [16:0] o_force_x,
    output logic signed [16:0] o_force_y,
    output logic               o_in_range
);

    localparam int LATENCY = 115;

    logic        r_busy;
    logic [23:0] r_radius;
    logic [15:0] r_strength;
    logic        w_accept;

    assign w_accept = i_start && !r_busy;
    assign o_busy   = r_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= sfa_pkg::RADIUS_RESET;
            r_strength <= sfa_pkg::STRENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfa_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data;
                sfa_pkg::CFG_STRENGTH: r_strength <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Front end: differences, products and the range test, five stages.
    logic signed [24:0] r1_dx, r1_dy;
    logic signed [15:0] r1_vx, r1_vy;
    logic        [15:0] r1_dt;
    logic               r1_v, r2_v, r3_v, r4_v, r5_v;

    logic        [47:0] r2_dxx, r2_dyy, r2_rsq;
    logic signed [32:0] r2_vxdt, r2_vydt;
    logic        [30:0] r2_vxx, r2_vyy;
    logic        [15:0] r2_dt;
    logic signed [24:0] r2_dx, r2_dy;

    logic        [48:0] w_dist2;
    logic signed [41:0] w_exs, w_eys;
    logic        [48:0] r3_dist2;
    logic signed [29:0] r3_ex, r3_ey;
    logic        [31:0] r3_sp2;
    logic               r3_inr;
    logic        [15:0] r3_dt;
    logic signed [24:0] r3_dx, r3_dy;

    logic        [57:0] r4_exx, r4_eyy;
    logic        [47:0] r4_sp2dt;
    logic        [15:0] r4_dt;
    logic        [48:0] r4_dist2;
    logic signed [24:0] r4_dx, r4_dy;
    logic               r4_inr;

    logic        [63:0] w_s2full;
    logic        [57:0] r5_e2;
    logic        [39:0] r5_s2;
    logic        [48:0] r5_dist2;
    logic signed [24:0] r5_dx, r5_dy;
    logic               r5_inr, r5_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r1_v   <= w_accept;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
        end
    end

    // The pair offset points from self to the other agent.
    assign w_dist2 = 49'(r2_dxx) + 49'(r2_dyy);
    // d - v*dt exactly in Q.24, with rounding to Q.12 by an arithmetic shift.
    assign w_exs = (42'(r2_dx) <<< 16) - 42'(r2_vxdt) + 42'sd2048;
    assign w_eys = (42'(r2_dy) <<< 16) - 42'(r2_vydt) + 42'sd2048;
    assign w_s2full = 64'(r4_sp2dt) * 64'(r4_dt);

    always_ff @(posedge i_clk) begin
        r1_dx <= 25'(i_other_pos_x) - 25'(i_self_pos_x);
        r1_dy <= 25'(i_other_pos_y) - 25'(i_self_pos_y);
        r1_vx <= i_other_vel_x;
        r1_vy <= i_other_vel_y;
        r1_dt <= i_time_step;

        r2_dxx  <= 48'(r1_dx * r1_dx);
        r2_dyy  <= 48'(r1_dy * r1_dy);
        r2_vxdt <= 33'(r1_vx) * 33'($signed({1'b0, r1_dt}));
        r2_vydt <= 33'(r1_vy) * 33'($signed({1'b0, r1_dt}));
        r2_vxx  <= 31'(r1_vx * r1_vx);
        r2_vyy  <= 31'(r1_vy * r1_vy);
        r2_rsq  <= 48'(r_radius) * 48'(r_radius);
        r2_dt   <= r1_dt;
        r2_dx   <= r1_dx;
        r2_dy   <= r1_dy;

        r3_dist2 <= w_dist2;
        r3_ex    <= w_exs[41:12];
        r3_ey    <= w_eys[41:12];
        r3_sp2   <= 32'(r2_vxx) + 32'(r2_vyy);
        r3_inr   <= w_dist2 <= 49'(r2_rsq);
        r3_dt    <= r2_dt;
        r3_dx    <= r2_dx;
        r3_dy    <= r2_dy;

        r4_exx   <= 58'(r3_ex * r3_ex);
        r4_eyy   <= 58'(r3_ey * r3_ey);
        r4_sp2dt <= 48'(r3_sp2) * 48'(r3_dt);
        r4_dt    <= r3_dt;
        r4_dist2 <= r3_dist2;
        r4_dx    <= r3_dx;
        r4_dy    <= r3_dy;
        r4_inr   <= r3_inr;

        r5_e2    <= r4_exx + r4_eyy;
        r5_s2    <= w_s2full[63:24];
        r5_dist2 <= r4_dist2;
        r5_dx    <= r4_dx;
        r5_dy    <= r4_dy;
        r5_inr   <= r4_inr;
        r5_nz    <= r4_dist2 != '0;
    end

    // Lengths |d| in Q.12 and |d - v*dt| in Q.12, and |d| in Q.15 for normalizing.
    logic [29:0] w_l1, w_l2;
    logic [31:0] w_dq;

    sfa_isqrt #(.IN_W(60)) u_sqrt_l1 (
        .i_clk  (i_clk),
        .i_x    ({3'b000, r5_dist2, 8'h00}),
        .o_root (w_l1)
    );

    sfa_isqrt #(.IN_W(60)) u_sqrt_l2 (
        .i_clk  (i_clk),
        .i_x    ({2'b00, r5_e2}),
        .o_root (w_l2)
    );

    sfa_isqrt #(.IN_W(64)) u_sqrt_dq (
        .i_clk  (i_clk),
        .i_x    ({1'b0, r5_dist2, 14'h0000}),
        .o_root (w_dq)
    );

    // The square of |v|*dt waits for the square of the sum of the two lengths.
    logic [39:0] w_s2_d;

    sfa_delay #(.W(40), .DEPTH(32)) u_dly_s2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r5_s2),
        .o_q     (w_s2_d)
    );

    // Ellipse axis: 2b = sqrt(max(T^2 - s^2, 0)).
    logic [30:0] r36_tt;
    logic [61:0] r37_t2;
    logic [61:0] r38_d;

    always_ff @(posedge i_clk) begin
        r36_tt <= 31'(w_l1) + 31'(w_l2);
        r37_t2 <= 62'(r36_tt) * 62'(r36_tt);
        r38_d  <= (r37_t2 > 62'(w_s2_d)) ? r37_t2 - 62'(w_s2_d) : '0;
    end

    logic [30:0] w_q;

    sfa_isqrt #(.IN_W(62)) u_sqrt_q (
        .i_clk  (i_clk),
        .i_x    (r38_d),
        .o_root (w_q)
    );

    // u = b/R in Q.16, saturated to 22 bits.
    logic [21:0] w_u;

    sfa_div #(.NUM_W(42), .DEN_W(24), .Q_W(22)) u_div_u (
        .i_clk (i_clk),
        .i_num ({w_q, 11'h000}),
        .i_den (r_radius),
        .o_quo (w_u)
    );

    // Potential exp(-u) = 2^-(u*log2 e), by table with linear interpolation.
    logic [38:0] r93_tm;
    logic [22:0] w_t;
    logic [3:0]  w_k;
    logic [4:0]  w_k1;
    logic [16:0] w_diff;
    logic [16:0] r94_m0;
    logic [23:0] r94_prod;
    logic [6:0]  r94_n;
    logic [16:0] w_m;
    logic [16:0] r95_pot;

    assign w_t    = r93_tm[38:16];
    assign w_k    = w_t[15:12];
    assign w_k1   = 5'(w_k) + 5'd1;
    assign w_diff = sfa_pkg::EXP2_TAB[w_k] - sfa_pkg::EXP2_TAB[w_k1];
    assign w_m    = r94_m0 - 17'(r94_prod[23:12]);

    always_ff @(posedge i_clk) begin
        r93_tm   <= 39'(w_u) * 39'(sfa_pkg::LOG2E_Q16);
        r94_m0   <= sfa_pkg::EXP2_TAB[w_k];
        r94_prod <= 24'(w_diff[11:0]) * 24'(w_t[11:0]);
        r94_n    <= w_t[22:16];
        r95_pot  <= (r94_n >= sfa_pkg::EXP_SHIFT_LIMIT) ? '0 : (w_m >> r94_n);
    end

    // Offset, flags and valid travel alongside the long units.
    logic [52:0]        w_sd;
    logic signed [24:0] w_sdx, w_sdy;
    logic               w_sv, w_sinr, w_snz;

    sfa_delay #(.W(53), .DEPTH(90)) u_dly_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     ({r5_v, r5_inr, r5_nz, r5_dx, r5_dy}),
        .o_q     (w_sd)
    );

    assign {w_sv, w_sinr, w_snz, w_sdx, w_sdy} = w_sd;

    // Force magnitude numerators |d_c| * P * S / 512.
    logic [23:0]       w_adx, w_ady;
    logic [40:0]       r96_ax, r96_ay;
    sfa_pkg::t_flags   r96_fl, r97_fl;
    logic [56:0]       w_nx, w_ny;
    logic [47:0]       r97_nx, r97_ny;

    assign w_adx = w_sdx[24] ? 24'(-w_sdx) : w_sdx[23:0];
    assign w_ady = w_sdy[24] ? 24'(-w_sdy) : w_sdy[23:0];
    assign w_nx  = 57'(r96_ax) * 57'(r_strength);
    assign w_ny  = 57'(r96_ay) * 57'(r_strength);

    always_ff @(posedge i_clk) begin
        r96_ax <= 41'(w_adx) * 41'(r95_pot);
        r96_ay <= 41'(w_ady) * 41'(r95_pot);
        r97_nx <= w_nx[56:9];
        r97_ny <= w_ny[56:9];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r96_fl <= '0;
            r97_fl <= '0;
        end else begin
            r96_fl.valid <= w_sv;
            r96_fl.inr   <= w_sinr;
            r96_fl.nz    <= w_snz;
            // The force points away from the other agent.
            r96_fl.negx  <= !w_sdx[24] && (w_sdx != '0);
            r96_fl.negy  <= !w_sdy[24] && (w_sdy != '0);
            r97_fl       <= r96_fl;
        end
    end

    logic [31:0] w_dq_d;

    sfa_delay #(.W(32), .DEPTH(60)) u_dly_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_dq),
        .o_q     (w_dq_d)
    );

    // Divide by |d|; a quotient that overflows 16 bits saturates to full scale.
    logic [15:0] w_magx, w_magy;

    sfa_div #(.NUM_W(48), .DEN_W(32), .Q_W(16)) u_div_fx (
        .i_clk (i_clk),
        .i_num (r97_nx),
        .i_den (w_dq_d),
        .o_quo (w_magx)
    );

    sfa_div #(.NUM_W(48), .DEN_W(32), .Q_W(16)) u_div_fy (
        .i_clk (i_clk),
        .i_num (r97_ny),
        .i_den (w_dq_d),
        .o_quo (w_magy)
    );

    sfa_pkg::t_flags w_fl;

    sfa_delay #(.W($bits(sfa_pkg::t_flags)), .DEPTH(17)) u_dly_fl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (r97_fl),
        .o_q     (w_fl)
    );

    // Output stage: sign, and zero force when out of range or for coincident agents.
    logic               r_done;
    logic signed [16:0] r_force_x, r_force_y;
    logic               r_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_fl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_range <= w_fl.inr;
        if (w_fl.inr && w_fl.nz) begin
            r_force_x <= w_fl.negx ? -$signed({1'b0, w_magx}) : $signed({1'b0, w_magx});
            r_force_y <= w_fl.negy ? -$signed({1'b0, w_magy}) : $signed({1'b0, w_magy});
        end else begin
            r_force_x <= '0;
            r_force_y <= '0;
        end
    end

    assign o_done     = r_done;
    assign o_force_x  = r_force_x;
    assign o_force_y  = r_force_y;
    assign o_in_range = r_in_range;

    // Every request produces its result after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("request did not produce a result after the pipeline latency");

    // A pair outside the radius carries no force.
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_in_range) |-> (o_force_x == '0 && o_force_y == '0))
        else $error("out of range result carries a nonzero force");

    // Saturation keeps both components within plus or minus full scale.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_force_x != 17'sh10000 && o_force_y != 17'sh10000))
        else $error("force component beyond saturation limit");

endmodule
